[hdl/assert_macros.svh]
// assertion macros used by the allocator rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   `ASSERT_AT(lbl, clk, rst, !(expr))

`endif

[hdl/ffa_pkg.sv]
// types and constants of the first fit region allocator
package ffa_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int IDX_W        = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_NOT_FOUND  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_SHIFT,
      FSM_RESP
   } fsm_type;

   typedef enum logic {
      REG_BASE = 1'b0,
      REG_SIZE = 1'b1
   } reg_type;

   typedef struct packed {
      op_type      opcode;
      logic [15:0] req_size;
      logic [15:0] owner_tag;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] block_offset;
      logic [15:0] block_size;
   } rsp_type;

   typedef struct packed {
      logic [15:0] off;
      logic [15:0] len;
      logic        is_free;
      logic [15:0] owner;
   } seg_type;

endpackage

[hdl/first_fit_tagged_region_allocator_top.sv]
// first fit region allocator with owner tags, sequenced over a segment memory
//
//  channel   ports                                 handshake
//  request   start, busy, req_payload              start high while busy low
//  result    rsp_strobe, rsp_payload               one cycle strobe, no stall
//  config    psel penable pwrite paddr pwdata ...  apb, pready always high
//
// sequence of a request: clear writes the single free entry and answers; query,
// allocate and free read one table entry a cycle from the segment memory; an
// allocate that splits an entry then moves each entry above it up by one a
// cycle. busy stays high until the result beat has gone. reset is synchronous
// and empties the table; the result side cannot stall.
`include "assert_macros.svh"

module first_fit_tagged_region_allocator_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ffa_pkg::req_type    req_payload,
   output logic                rsp_strobe,
   output ffa_pkg::rsp_type    rsp_payload,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int IW = ffa_pkg::IDX_W;
   localparam int CW = ffa_pkg::CNT_W;

   ffa_pkg::fsm_type  state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [15:0]       base_ff, size_ff;
   ffa_pkg::req_type  req_ff, req_in;
   ffa_pkg::rsp_type  res_ff, res_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic              dv_ff, dv_in;
   logic [IW-1:0]     didx_ff, didx_in;
   ffa_pkg::seg_type  acc_ff, acc_in;
   logic              accv_ff, accv_in;
   logic [CW-1:0]     wptr_ff, wptr_in;
   logic              any_ff, any_in;
   ffa_pkg::seg_type  carry_ff, carry_in;

   ffa_pkg::seg_type  mem [ffa_pkg::MAX_SEGMENTS];
   ffa_pkg::seg_type  rd_data_ff;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   ffa_pkg::seg_type  wr_data;

   logic              finish, to_shift;
   ffa_pkg::seg_type  fe;

   // segment memory, one read and one write per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // configuration registers
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (ffa_pkg::reg_type'(paddr[2]))
            ffa_pkg::REG_BASE: base_ff <= pwdata[15:0];
            ffa_pkg::REG_SIZE: size_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ffa_pkg::reg_type'(paddr[2]))
         ffa_pkg::REG_BASE: prdata = {16'd0, base_ff};
         ffa_pkg::REG_SIZE: prdata = {16'd0, size_ff};
         default:           prdata = '0;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::FSM_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff   <= req_in;
      res_ff   <= res_in;
      ptr_ff   <= ptr_in;
      dv_ff    <= dv_in;
      didx_ff  <= didx_in;
      acc_ff   <= acc_in;
      accv_ff  <= accv_in;
      wptr_ff  <= wptr_in;
      any_ff   <= any_in;
      carry_ff <= carry_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffa_pkg::FSM_IDLE: begin
            if (start) state_in = ffa_pkg::FSM_SCAN;
         end
         ffa_pkg::FSM_SCAN: begin
            if (to_shift)    state_in = ffa_pkg::FSM_SHIFT;
            else if (finish) state_in = ffa_pkg::FSM_RESP;
         end
         ffa_pkg::FSM_SHIFT: begin
            if (finish) state_in = ffa_pkg::FSM_RESP;
         end
         ffa_pkg::FSM_RESP: state_in = ffa_pkg::FSM_IDLE;
         default:           state_in = ffa_pkg::FSM_IDLE;
      endcase
   end

   // entry of the free pass after releasing a matching tag
   always_comb begin
      fe = rd_data_ff;
      if (!rd_data_ff.is_free && rd_data_ff.owner == req_ff.owner_tag) begin
         fe.is_free = 1'b1;
         fe.owner   = '0;
      end
   end

   // datapath and memory control
   always_comb begin
      count_in = count_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      ptr_in   = ptr_ff;
      dv_in    = 1'b0;
      didx_in  = didx_ff;
      acc_in   = acc_ff;
      accv_in  = accv_ff;
      wptr_in  = wptr_ff;
      any_in   = any_ff;
      carry_in = carry_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff[IW-1:0];
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = rd_data_ff;
      finish   = 1'b0;
      to_shift = 1'b0;
      case (state_ff)
         ffa_pkg::FSM_IDLE: begin
            if (start) begin
               req_in  = req_payload;
               ptr_in  = '0;
               accv_in = 1'b0;
               wptr_in = '0;
               any_in  = 1'b0;
            end
         end
         ffa_pkg::FSM_SCAN: begin
            // stream entries in order, one read a cycle
            rd_en   = (ptr_ff < count_ff);
            ptr_in  = rd_en ? ptr_ff + CW'(1) : ptr_ff;
            dv_in   = rd_en;
            didx_in = ptr_ff[IW-1:0];
            case (req_ff.opcode)
               ffa_pkg::OP_CLEAR: begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = '{off: base_ff, len: size_ff, is_free: 1'b1, owner: 16'd0};
                  count_in = CW'(1);
                  res_in   = '{status: ffa_pkg::ST_OK, block_offset: 16'd0,
                               block_size: 16'd0};
                  finish   = 1'b1;
               end
               ffa_pkg::OP_ALLOC: begin
                  if (dv_ff && rd_data_ff.is_free && rd_data_ff.len >= req_ff.req_size) begin
                     if (rd_data_ff.len == req_ff.req_size) begin
                        wr_en   = 1'b1;
                        wr_addr = didx_ff;
                        wr_data = '{off: rd_data_ff.off, len: rd_data_ff.len,
                                    is_free: 1'b0, owner: req_ff.owner_tag};
                        res_in  = '{status: ffa_pkg::ST_OK, block_offset: rd_data_ff.off,
                                    block_size: req_ff.req_size};
                        finish  = 1'b1;
                     end else if (count_ff == CW'(ffa_pkg::MAX_SEGMENTS)) begin
                        res_in = '{status: ffa_pkg::ST_TABLE_FULL, block_offset: 16'd0,
                                   block_size: 16'd0};
                        finish = 1'b1;
                     end else begin
                        // split: used part in place, remainder shifted in after it
                        wr_en    = 1'b1;
                        wr_addr  = didx_ff;
                        wr_data  = '{off: rd_data_ff.off, len: req_ff.req_size,
                                     is_free: 1'b0, owner: req_ff.owner_tag};
                        carry_in = '{off: rd_data_ff.off + req_ff.req_size,
                                     len: rd_data_ff.len - req_ff.req_size,
                                     is_free: 1'b1, owner: 16'd0};
                        res_in   = '{status: ffa_pkg::ST_OK, block_offset: rd_data_ff.off,
                                     block_size: req_ff.req_size};
                        ptr_in   = {1'b0, didx_ff} + CW'(1);
                        dv_in    = 1'b0;
                        to_shift = 1'b1;
                     end
                  end else if (!dv_ff && ptr_ff >= count_ff) begin
                     res_in = '{status: ffa_pkg::ST_NO_SPACE, block_offset: 16'd0,
                                block_size: 16'd0};
                     finish = 1'b1;
                  end
               end
               ffa_pkg::OP_FREE: begin
                  if (dv_ff) begin
                     if (!rd_data_ff.is_free && rd_data_ff.owner == req_ff.owner_tag) begin
                        any_in = 1'b1;
                     end
                     // merge free runs, compacting towards the bottom
                     if (accv_ff && acc_ff.is_free && fe.is_free) begin
                        acc_in.len = acc_ff.len + fe.len;
                     end else begin
                        if (accv_ff) begin
                           wr_en   = 1'b1;
                           wr_addr = wptr_ff[IW-1:0];
                           wr_data = acc_ff;
                           wptr_in = wptr_ff + CW'(1);
                        end
                        acc_in  = fe;
                        accv_in = 1'b1;
                     end
                  end else if (ptr_ff >= count_ff) begin
                     if (accv_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = wptr_ff[IW-1:0];
                        wr_data = acc_ff;
                     end
                     count_in = wptr_ff + CW'(accv_ff);
                     res_in   = '{status: any_ff ? ffa_pkg::ST_OK : ffa_pkg::ST_NOT_FOUND,
                                  block_offset: 16'd0, block_size: 16'd0};
                     finish   = 1'b1;
                  end
               end
               ffa_pkg::OP_QUERY: begin
                  if (dv_ff && !rd_data_ff.is_free && rd_data_ff.owner == req_ff.owner_tag) begin
                     res_in = '{status: ffa_pkg::ST_OK, block_offset: rd_data_ff.off,
                                block_size: rd_data_ff.len};
                     finish = 1'b1;
                  end else if (!dv_ff && ptr_ff >= count_ff) begin
                     res_in = '{status: ffa_pkg::ST_NOT_FOUND, block_offset: 16'd0,
                                block_size: 16'd0};
                     finish = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ffa_pkg::FSM_SHIFT: begin
            // move entries up by one, carrying the displaced entry
            rd_en   = (ptr_ff < count_ff);
            ptr_in  = rd_en ? ptr_ff + CW'(1) : ptr_ff;
            dv_in   = rd_en;
            didx_in = ptr_ff[IW-1:0];
            if (dv_ff) begin
               wr_en    = 1'b1;
               wr_addr  = didx_ff;
               wr_data  = carry_ff;
               carry_in = rd_data_ff;
            end else if (ptr_ff >= count_ff) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               wr_data  = carry_ff;
               count_in = count_ff + CW'(1);
               finish   = 1'b1;
            end
         end
         ffa_pkg::FSM_RESP: ;
         default: ;
      endcase
   end

   // handshake outputs
   assign busy        = (state_ff != ffa_pkg::FSM_IDLE);
   assign rsp_strobe  = (state_ff == ffa_pkg::FSM_RESP);
   assign rsp_payload = res_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CW'(ffa_pkg::MAX_SEGMENTS))
   `ASSERT_AT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `ASSERT_AT(a_start_busy, clock, reset, (start && !busy) |=> busy)
   `ASSERT_NEVER(a_write_in_idle, clock, reset, wr_en && !busy)

endmodule

[sim/first_fit_tagged_region_allocator_top_tb.sv]
// testbench of the first fit region allocator: directed and random requests
`timescale 1ns / 1ps

module first_fit_tagged_region_allocator_top_tb;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ffa_pkg::req_type  req_payload = '0;
   logic              rsp_strobe;
   ffa_pkg::rsp_type  rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   first_fit_tagged_region_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   // shadow of the segment table
   ffa_pkg::seg_type  shadow_seg[ffa_pkg::MAX_SEGMENTS];
   int                shadow_count;
   logic [15:0]       cfg_base;
   logic [15:0]       cfg_size;

   ffa_pkg::rsp_type  pending_rsp[$];
   int                error_count;
   int                sent_count;
   int                ok_allocs;
   int                full_hits;

   function automatic void shadow_remove(input int idx);
      for (int k = idx; k + 1 < shadow_count; k++) shadow_seg[k] = shadow_seg[k + 1];
      shadow_count--;
   endfunction

   // allocator behaviour for one request
   function automatic ffa_pkg::rsp_type predict_alloc(input ffa_pkg::req_type rq);
      ffa_pkg::rsp_type r;
      ffa_pkg::seg_type q;
      logic [15:0]      sz;
      int               i;
      bit               hit;
      r = '0;
      sz = rq.req_size;
      case (rq.opcode)
         ffa_pkg::OP_CLEAR: begin
            shadow_seg[0] = '{off: cfg_base, len: cfg_size, is_free: 1'b1, owner: 16'd0};
            shadow_count = 1;
            r.status = ffa_pkg::ST_OK;
         end
         ffa_pkg::OP_ALLOC: begin
            r.status = ffa_pkg::ST_NO_SPACE;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_seg[i].is_free && shadow_seg[i].len >= sz) begin
                  if (shadow_seg[i].len != sz) begin
                     if (shadow_count >= ffa_pkg::MAX_SEGMENTS) begin
                        r.status = ffa_pkg::ST_TABLE_FULL;
                        break;
                     end
                     q = '{off: shadow_seg[i].off + sz, len: shadow_seg[i].len - sz,
                           is_free: 1'b1, owner: 16'd0};
                     shadow_seg[i].len = sz;
                     for (int k = shadow_count; k > i + 1; k--) shadow_seg[k] = shadow_seg[k - 1];
                     shadow_seg[i + 1] = q;
                     shadow_count++;
                  end
                  shadow_seg[i].is_free = 1'b0;
                  shadow_seg[i].owner = rq.owner_tag;
                  r.status = ffa_pkg::ST_OK;
                  r.block_offset = shadow_seg[i].off;
                  r.block_size = sz;
                  break;
               end
            end
         end
         ffa_pkg::OP_FREE: begin
            hit = 1'b0;
            i = 0;
            while (i < shadow_count) begin
               if (!shadow_seg[i].is_free && shadow_seg[i].owner == rq.owner_tag) begin
                  hit = 1'b1;
                  shadow_seg[i].is_free = 1'b1;
                  shadow_seg[i].owner = 16'd0;
                  if (i + 1 < shadow_count && shadow_seg[i + 1].is_free) begin
                     shadow_seg[i].len = shadow_seg[i].len + shadow_seg[i + 1].len;
                     shadow_remove(i + 1);
                  end
                  if (i > 0 && shadow_seg[i - 1].is_free) begin
                     shadow_seg[i - 1].len = shadow_seg[i - 1].len + shadow_seg[i].len;
                     shadow_remove(i);
                     i--;
                  end
               end
               i++;
            end
            r.status = hit ? ffa_pkg::ST_OK : ffa_pkg::ST_NOT_FOUND;
         end
         default: begin
            r.status = ffa_pkg::ST_NOT_FOUND;
            for (i = 0; i < shadow_count; i++) begin
               if (!shadow_seg[i].is_free && shadow_seg[i].owner == rq.owner_tag) begin
                  r.status = ffa_pkg::ST_OK;
                  r.block_offset = shadow_seg[i].off;
                  r.block_size = shadow_seg[i].len;
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   // send one request beat after a random gap
   task automatic send_request(input ffa_pkg::op_type op, input logic [15:0] sz,
                               input logic [15:0] tag);
      ffa_pkg::req_type rq;
      ffa_pkg::rsp_type r;
      int               gap;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clock);
      rq.opcode = op;
      rq.req_size = sz;
      rq.owner_tag = tag;
      start <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      r = predict_alloc(rq);
      if (r.status == ffa_pkg::ST_OK && op == ffa_pkg::OP_ALLOC) ok_allocs++;
      if (r.status == ffa_pkg::ST_TABLE_FULL) full_hits++;
      pending_rsp.push_back(r);
      sent_count++;
      // the block is busy here anyway, so the next beat loses no time
      @(posedge clock);
   endtask

   // wait for the block to drain before touching registers
   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input ffa_pkg::reg_type idx, input logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * int'(idx));
      pwdata <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == ffa_pkg::REG_BASE) cfg_base = value;
      else cfg_size = value;
   endtask

   task automatic set_region(input logic [15:0] base, input logic [15:0] size);
      wait_drained();
      write_reg(ffa_pkg::REG_BASE, base);
      write_reg(ffa_pkg::REG_SIZE, size);
   endtask

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      ffa_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with no expectation waiting");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_payload.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.block_offset !== e.block_offset) begin
               $error("block_offset: expected %0h, got %0h", e.block_offset,
                      rsp_payload.block_offset);
               error_count++;
            end
            if (rsp_payload.block_size !== e.block_size) begin
               $error("block_size: expected %0h, got %0h", e.block_size,
                      rsp_payload.block_size);
               error_count++;
            end
         end
      end
   end

   // empty table, extremes, zero size, wrap, table full
   task automatic test_directed();
      send_request(ffa_pkg::OP_ALLOC, 16'd4, 16'h1);
      send_request(ffa_pkg::OP_FREE, 16'd0, 16'h1);
      send_request(ffa_pkg::OP_QUERY, 16'd0, 16'h1);
      set_region(16'hFFF0, 16'hFFFF);
      send_request(ffa_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
      send_request(ffa_pkg::OP_ALLOC, 16'd0, 16'hFFFF);
      send_request(ffa_pkg::OP_ALLOC, 16'h0020, 16'h0000);
      send_request(ffa_pkg::OP_ALLOC, 16'hFFFF, 16'h5555);
      send_request(ffa_pkg::OP_QUERY, 16'd0, 16'h0000);
      send_request(ffa_pkg::OP_FREE, 16'd0, 16'hFFFF);
      send_request(ffa_pkg::OP_FREE, 16'd0, 16'h0000);
      send_request(ffa_pkg::OP_ALLOC, 16'hFFFF, 16'hAAAA);
      send_request(ffa_pkg::OP_QUERY, 16'hFFFF, 16'hAAAA);
      send_request(ffa_pkg::OP_FREE, 16'd0, 16'hAAAA);
      set_region(16'h0000, 16'd40);
      send_request(ffa_pkg::OP_CLEAR, 16'd0, 16'd0);
      for (int k = 0; k < 33; k++) send_request(ffa_pkg::OP_ALLOC, 16'd1, 16'(k % 3));
      send_request(ffa_pkg::OP_FREE, 16'd0, 16'd1);
      send_request(ffa_pkg::OP_ALLOC, 16'd0, 16'd7);
   endtask

   // random sequences of clears, allocations, frees and queries over several regions
   task automatic test_random();
      logic [15:0] sz;
      int          op_pick;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_region(16'h0000, 16'hFFFF);
            1: set_region(16'hFFFF, 16'h0000);
            default: set_region(16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)));
         endcase
         send_request(ffa_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
         for (int n = 0; n < 145; n++) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 3) begin
               send_request(ffa_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
            end else if (op_pick < 50) begin
               case ($urandom_range(0, 3))
                  0: sz = 16'($urandom_range(0, 65535));
                  1: sz = 16'd0;
                  default: sz = 16'($urandom_range(1, 4000));
               endcase
               send_request(ffa_pkg::OP_ALLOC, sz,
                            $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                                 : 16'($urandom_range(0, 65535)));
            end else if (op_pick < 80) begin
               send_request(ffa_pkg::OP_FREE, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 9)));
            end else begin
               send_request(ffa_pkg::OP_QUERY, 16'($urandom_range(0, 65535)),
                            $urandom_range(0, 1) ? 16'($urandom_range(0, 9))
                                                 : 16'($urandom_range(0, 65535)));
            end
         end
      end
   endtask

   initial begin
      error_count = 0;
      sent_count = 0;
      ok_allocs = 0;
      full_hits = 0;
      shadow_count = 0;
      cfg_base = '0;
      cfg_size = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      wait_drained();
      $display("sent %0d requests, %0d allocations granted, %0d table full answers",
               sent_count, ok_allocs, full_hits);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

endmodule
